FILE: src/zob_pkg.sv
// Package: widths, masks, search state and the per-bit BIGMIN step.
`timescale 1ns / 1ps

package zob_pkg;

    localparam int unsigned CODE_W          = 64;
    localparam int unsigned POS_W           = $clog2(CODE_W);
    localparam int unsigned STEPS_PER_STAGE = 8;
    localparam int unsigned NUM_STAGES      = CODE_W / STEPS_PER_STAGE;
    localparam int unsigned S_TDATA_W       = 3 * CODE_W;
    localparam int unsigned M_TDATA_W       = CODE_W;

    // Interleave masks: even bits belong to one dimension, odd bits to the other
    localparam logic [CODE_W-1:0] EVEN_MASK = 64'h5555_5555_5555_5555;
    localparam logic [CODE_W-1:0] ODD_MASK  = 64'haaaa_aaaa_aaaa_aaaa;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] hi;
        logic [CODE_W-1:0] cand;    // candidate, or the answer once search stops
        logic              active;  // still scanning bits
        logic              fault;
    } srch_t;

    // One bit position of the scan
    function automatic srch_t bigmin_step(input srch_t s, input logic [POS_W-1:0] pos);
        logic [CODE_W-1:0] bit_m;
        logic [CODE_W-1:0] below;
        logic [CODE_W-1:0] same;
        logic [CODE_W-1:0] keep;
        logic [CODE_W-1:0] ones;
        logic [2:0]        sel;
        srch_t             r;
        r     = s;
        bit_m = {{(CODE_W-1){1'b0}}, 1'b1} << pos;
        below = {CODE_W{1'b1}} >> (POS_W'(CODE_W - 1) - pos);
        same  = (pos[0] ? ODD_MASK : EVEN_MASK) & below;
        keep  = ~same;
        ones  = same & ~bit_m;
        sel   = {s.code[pos], s.lo[pos], s.hi[pos]};
        if (s.active) begin
            case (sel)
                3'b000, 3'b111: begin
                end
                3'b001: begin
                    r.cand = (s.lo & keep) | bit_m;
                    r.hi   = (s.hi & keep) | ones;
                end
                3'b011: begin
                    r.cand   = s.lo;
                    r.active = 1'b0;
                end
                3'b100: begin
                    r.active = 1'b0;
                end
                3'b101: begin
                    r.lo = (s.lo & keep) | bit_m;
                end
                default: begin
                    // low bit set with high bit clear cannot happen on a valid box
                    r.fault  = 1'b1;
                    r.active = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

FILE: src/zob_stage.sv
// One pipeline stage: a group of bit steps of the BIGMIN scan, registered.
`timescale 1ns / 1ps

module zob_stage #(
    parameter int unsigned FIRST_POS = zob_pkg::CODE_W - 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  zob_pkg::srch_t in_state,
    output logic          out_valid,
    input  logic          out_ready,
    output zob_pkg::srch_t out_state
);
    import zob_pkg::*;

    logic  valid_reg;
    srch_t state_reg;
    srch_t state_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_state = state_reg;

    // bits FIRST_POS down to FIRST_POS-7, most significant first
    always_comb begin
        state_next = in_state;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            state_next = bigmin_step(state_next, POS_W'(FIRST_POS - k));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/z_order_bigmin_core.sv
// Top level: BIGMIN for 2-D 64-bit Morton codes, fully pipelined.
// Registers in order: entry stage, 8 scan stages of 8 bits each over the 64-bit code, output.
// Throughput: one beat per cycle when the result side does not stall.
// Each stage holds its beat under back-pressure and fills any bubble ahead of it.
// Reset (aresetn low, synchronous) empties every stage; data registers are not cleared.
`timescale 1ns / 1ps

module z_order_bigmin_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata, low bit up: code_value[63:0], box_low_code[63:0], box_high_code[63:0]
    input  logic [zob_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata, low bit up: next_inside_code[63:0]
    output logic [zob_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: fault
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import zob_pkg::*;

    // Entry stage: unpack, range check
    logic  entry_valid_reg;
    srch_t entry_state_reg;
    srch_t entry_state_next;

    // Scan pipeline links; index g feeds stage g
    logic  pipe_valid [0:NUM_STAGES];
    logic  pipe_ready [0:NUM_STAGES];
    srch_t pipe_state [0:NUM_STAGES];

    // Output register
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_data_reg;
    logic              out_fault_reg;
    logic [CODE_W-1:0] out_data_next;
    logic              out_fault_next;

    logic              in_take;

    assign in_take  = s_tvalid && s_tready;
    assign s_tready = !entry_valid_reg || pipe_ready[0];

    always_comb begin
        entry_state_next.code   = s_tdata[CODE_W-1:0];
        entry_state_next.lo     = s_tdata[2*CODE_W-1:CODE_W];
        entry_state_next.hi     = s_tdata[3*CODE_W-1:2*CODE_W];
        entry_state_next.cand   = s_tdata[2*CODE_W-1:CODE_W];
        // code must lie in [lo, hi)
        entry_state_next.fault  = (s_tdata[CODE_W-1:0] < s_tdata[2*CODE_W-1:CODE_W]) ||
                                  (s_tdata[CODE_W-1:0] >= s_tdata[3*CODE_W-1:2*CODE_W]);
        entry_state_next.active = !entry_state_next.fault;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (s_tready) begin
            entry_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            entry_state_reg <= entry_state_next;
        end
    end

    assign pipe_valid[0] = entry_valid_reg;
    assign pipe_state[0] = entry_state_reg;

    // Bit scan, MSB first; stage g covers bits 63-8g down to 56-8g
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_scan
        zob_stage #(
            .FIRST_POS(CODE_W - 1 - g * STEPS_PER_STAGE)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_state  (pipe_state[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_state (pipe_state[g+1])
        );
    end

    assign pipe_ready[NUM_STAGES] = !out_valid_reg || m_tready;

    // Final check: the answer must sit strictly above the code, else fault with zero
    always_comb begin
        out_fault_next = pipe_state[NUM_STAGES].fault ||
                         (pipe_state[NUM_STAGES].cand <= pipe_state[NUM_STAGES].code);
        out_data_next  = out_fault_next ? '0 : pipe_state[NUM_STAGES].cand;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_ready[NUM_STAGES]) begin
            out_valid_reg <= pipe_valid[NUM_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ready[NUM_STAGES] && pipe_valid[NUM_STAGES]) begin
            out_data_reg  <= out_data_next;
            out_fault_reg <= out_fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fault_reg;

endmodule

FILE: dv/tb_top.sv
// Testbench for z_order_bigmin_core: random and directed BIGMIN queries, scoreboard check.
`timescale 1ns / 1ps

module tb_top;

    import zob_pkg::*;

    typedef logic [CODE_W-1:0] zcode_t;

    typedef struct packed {
        zcode_t next_code;
        logic   fault;
    } bigmin_answer_t;

    // Per-bit selector {code, low corner, high corner}
    localparam logic [2:0] SEL_BOTH_CLEAR = 3'b000;
    localparam logic [2:0] SEL_SPLIT      = 3'b001;
    localparam logic [2:0] SEL_BOX_ABOVE  = 3'b011;
    localparam logic [2:0] SEL_BOX_BELOW  = 3'b100;
    localparam logic [2:0] SEL_UPPER_HALF = 3'b101;
    localparam logic [2:0] SEL_BOTH_SET   = 3'b111;

    localparam zcode_t ODD_BELOW_TOP = 64'h2aaa_aaaa_aaaa_aaaa;
    localparam zcode_t TOP_BIT       = 64'h8000_0000_0000_0000;
    localparam zcode_t ALL_ONES      = '1;

    localparam int RANDOM_QUERIES = 1400;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 20;

    // Expected answers in beat order, checked against the result channel
    class bigmin_ledger;
        bigmin_answer_t awaited[$];
        int             mismatches;

        function automatic bigmin_answer_t bigmin_of(zcode_t code, zcode_t lo_in, zcode_t hi_in);
            zcode_t         lo;
            zcode_t         hi;
            zcode_t         cand;
            zcode_t         keep;
            zcode_t         ones;
            zcode_t         bit_m;
            logic [2:0]     sel;
            bigmin_answer_t r;
            lo   = lo_in;
            hi   = hi_in;
            cand = lo;
            keep = EVEN_MASK;
            ones = ODD_BELOW_TOP;
            bit_m = TOP_BIT;
            r.next_code = '0;
            r.fault     = 1'b1;
            if (code < lo || code >= hi)
                return r;
            for (int i = 0; i < CODE_W; i++) begin
                sel = {(code & bit_m) != 0, (lo & bit_m) != 0, (hi & bit_m) != 0};
                case (sel)
                    SEL_BOTH_CLEAR, SEL_BOTH_SET: begin
                    end
                    SEL_SPLIT: begin
                        cand = (lo & keep) | bit_m;
                        hi   = (hi & keep) | ones;
                    end
                    SEL_BOX_ABOVE: begin
                        if (lo > code) begin
                            r.next_code = lo;
                            r.fault     = 1'b0;
                        end
                        return r;
                    end
                    SEL_BOX_BELOW: begin
                        if (cand > code) begin
                            r.next_code = cand;
                            r.fault     = 1'b0;
                        end
                        return r;
                    end
                    SEL_UPPER_HALF: begin
                        lo = (lo & keep) | bit_m;
                    end
                    default: begin
                        // low corner bit set above a clear high corner bit
                        return r;
                    end
                endcase
                bit_m = bit_m >> 1;
                ones  = ones >> 1;
                keep  = (keep >> 1) | TOP_BIT;
            end
            if (cand > code) begin
                r.next_code = cand;
                r.fault     = 1'b0;
            end
            return r;
        endfunction

        function void note_query(zcode_t code, zcode_t lo, zcode_t hi);
            awaited.push_back(bigmin_of(code, lo, hi));
        endfunction

        function void check_answer(zcode_t next_code, logic fault);
            bigmin_answer_t exp_a;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: code=%h fault=%b", next_code, fault);
                return;
            end
            exp_a = awaited.pop_front();
            if (next_code !== exp_a.next_code || fault !== exp_a.fault) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected code=%h fault=%b, got code=%h fault=%b",
                             exp_a.next_code, exp_a.fault, next_code, fault);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    bigmin_ledger ledger = new();
    bit           calm   = 1'b0;
    int           cycle_count = 0;

    z_order_bigmin_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Odd bits carry x, even bits carry y
    function automatic zcode_t weave(logic [31:0] xv, logic [31:0] yv);
        zcode_t z;
        for (int i = 0; i < 32; i++) begin
            z[2*i+1] = xv[i];
            z[2*i]   = yv[i];
        end
        return z;
    endfunction

    // Upper corner coordinate: base plus a random extent of up to w bits, clamped
    function automatic logic [31:0] stretch(logic [31:0] base, int w);
        logic [32:0] mask;
        logic [32:0] sum;
        mask = (33'h1 << w) - 33'h1;
        sum  = {1'b0, base} + ({1'b0, $urandom()} & mask);
        return sum[32] ? 32'hffff_ffff : sum[31:0];
    endfunction

    function automatic zcode_t rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_query(zcode_t code, zcode_t lo, zcode_t hi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {hi, lo, code};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        ledger.note_query(code, lo, hi);
    endtask

    // Sender goes quiet until the pipeline has handed back every answer
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (ledger.pending() != 0);
    endtask

    task automatic random_query();
        logic [31:0] x0, x1, y0, y1, tmp;
        zcode_t      lo, hi, code;
        int          kind;
        x0   = $urandom();
        y0   = $urandom();
        x1   = stretch(x0, $urandom_range(1, 32));
        y1   = stretch(y0, $urandom_range(1, 32));
        kind = $urandom_range(0, 99);
        if (kind == 80) begin
            // corners crossed in x: impossible bit pairs show up
            tmp = x0;
            x0  = x1;
            x1  = tmp;
        end
        lo = weave(x0, y0);
        hi = weave(x1, y1);
        if (hi > lo)
            code = lo + rand64() % (hi - lo);
        else
            code = rand64();
        if (kind < 5)
            code = lo;
        else if (kind < 10 && hi > lo)
            code = hi - 1;
        else if (kind >= 75 && kind < 80)
            code = (lo > 0) ? lo - 1 - (rand64() % lo) : rand64();
        else if (kind >= 81 && kind < 90)
            code = hi + (rand64() % (ALL_ONES - hi + 1));
        else if (kind >= 90) begin
            code = rand64();
            lo   = rand64();
            hi   = rand64();
        end
        send_query(code, lo, hi);
    endtask

    // Result side: random stall before each beat, none while calm
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            ledger.check_answer(m_tdata, m_tuser);
        end
    end

    initial begin
        zcode_t lo_s, hi_s;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, range faults, impossible combination, each scan case
        send_query('0, '0, ALL_ONES);
        send_query(ALL_ONES - 1, '0, ALL_ONES);
        send_query(ALL_ONES, '0, ALL_ONES);                    // at high corner
        send_query('0, 64'h1, ALL_ONES);                       // below low corner
        send_query(64'h1234, 64'h1000, 64'h1234);              // equal to high corner
        send_query(64'h5, 64'h5, 64'h5);                       // empty box
        send_query('0, ALL_ONES, ALL_ONES);
        send_query(64'h5000_0000_0000_0000, 64'h4000_0000_0000_0000,
                   64'h8000_0000_0000_0000);                   // low bit set, high clear
        send_query('0, '0, 64'h1);                             // answer after the full scan
        lo_s = weave(32'd2, 32'd2);
        hi_s = weave(32'd5, 32'd5);
        send_query(weave(32'd1, 32'd4), lo_s, hi_s);
        send_query(weave(32'd4, 32'd1), lo_s, hi_s);
        send_query(weave(32'd3, 32'd3), lo_s, hi_s);           // point inside the box
        send_query(weave(32'd6, 32'd2), lo_s, hi_s);
        send_query(weave(32'd2, 32'd6), lo_s, hi_s);
        send_query(lo_s, lo_s, hi_s);
        send_query(hi_s - 1, lo_s, hi_s);
        lo_s = weave(32'h7fff_0000, 32'h0000_0000);
        hi_s = weave(32'hffff_ffff, 32'hffff_ffff);
        send_query(lo_s + 1, lo_s, hi_s);
        send_query(weave(32'h7fff_ffff, 32'hffff_ffff), lo_s, hi_s);
        send_query(hi_s - 1, lo_s, hi_s);
        lo_s = weave(32'h0, 32'hffff_0000);
        hi_s = weave(32'hffff_ffff, 32'hffff_ffff);
        send_query(weave(32'h0000_0001, 32'h0000_0000), lo_s, hi_s);
        drain();

        for (int n = 0; n < RANDOM_QUERIES; n++) begin
            if ($urandom_range(0, 59) == 0)
                calm = ~calm;
            if (n % 350 == 349)
                drain();
            random_query();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
src/zob_pkg.sv
src/zob_stage.sv
src/z_order_bigmin_core.sv
dv/tb_top.sv
